@@ hdl/mep_pkg.sv @@
// ----------------------------------------------------------------------------
// mep_pkg: shared types and constants for the majority element search
// Item and result structs, the sequencer state type, the fallback stack
// control and status structs, and the sizes derived from MAX_ITEMS.
// ----------------------------------------------------------------------------
package mep_pkg;

    // Largest set that the element store holds.
    localparam int MAX_ITEMS = 1024;

    localparam int DATA_W = 32;
    localparam int CNT_W  = $clog2(MAX_ITEMS + 1);
    localparam int ADDR_W = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;

    // One fallback entry per reduction level; a set of MAX_ITEMS items
    // needs at most ADDR_W levels, plus one entry of margin.
    localparam int FB_DEPTH = ADDR_W + 1;
    localparam int FB_PTR_W = $clog2(FB_DEPTH + 1);
    localparam int FB_IDX_W = (FB_DEPTH > 1) ? $clog2(FB_DEPTH) : 1;

    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ITEMS);

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     last;
    } in_item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] majority;
        logic                     found;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_LVL_START,
        ST_SWEEP,
        ST_CAND_RD,
        ST_UNWIND,
        ST_COUNT,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic              push;
        logic              pop;
        logic              odd;
        logic [DATA_W-1:0] value;
    } fb_ctrl_t;

    typedef struct packed {
        logic              empty;
        logic              vld;
        logic [DATA_W-1:0] value;
    } fb_top_t;

endpackage

@@ hdl/mep_ram.sv @@
// ----------------------------------------------------------------------------
// mep_ram: simple dual-port memory
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module mep_ram #(
    parameter int DATA_W = 32,
    parameter int ADDR_W = 10
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    localparam int DEPTH = 1 << ADDR_W;

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ hdl/mep_fb_stack.sv @@
// ----------------------------------------------------------------------------
// mep_fb_stack: fallback stack of the reduction levels
// Each level pushes its last item and whether the level was odd; the
// unwind pass pops the entries from the deepest level upward.
// ----------------------------------------------------------------------------
module mep_fb_stack (
    input  logic               clk,
    input  logic               rst_n,
    input  mep_pkg::fb_ctrl_t  ctrl,
    output mep_pkg::fb_top_t   top
);

    logic [mep_pkg::FB_PTR_W-1:0] depth_reg;
    logic [mep_pkg::FB_PTR_W-1:0] depth_next;
    logic [mep_pkg::FB_PTR_W-1:0] top_ptr;
    logic [mep_pkg::FB_IDX_W-1:0] push_idx;
    logic [mep_pkg::FB_IDX_W-1:0] top_idx;

    logic                        vld_reg [mep_pkg::FB_DEPTH];
    logic [mep_pkg::DATA_W-1:0]  val_reg [mep_pkg::FB_DEPTH];

    assign top_ptr  = depth_reg - 1'b1;
    assign push_idx = depth_reg[mep_pkg::FB_IDX_W-1:0];
    assign top_idx  = top_ptr[mep_pkg::FB_IDX_W-1:0];

    always_comb
    begin
        priority if (ctrl.push)
        begin
            depth_next = depth_reg + 1'b1;
        end
        else if (ctrl.pop && (depth_reg != '0))
        begin
            depth_next = top_ptr;
        end
        else
        begin
            depth_next = depth_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg <= '0;
        end
        else
        begin
            depth_reg <= depth_next;
        end
    end

    // Entries are always pushed before they are popped, so they need no reset.
    always_ff @(posedge clk)
    begin
        if (ctrl.push)
        begin
            vld_reg[push_idx] <= ctrl.odd;
            val_reg[push_idx] <= ctrl.value;
        end
    end

    assign top.empty = (depth_reg == '0);
    assign top.vld   = vld_reg[top_idx];
    assign top.value = val_reg[top_idx];

endmodule

@@ hdl/majority_element_pairing.sv @@
// ----------------------------------------------------------------------------
// majority_element_pairing: majority element by pairwise elimination
// Loads a set of signed values, reduces it level by level to a candidate,
// then counts the candidate over the stored set and reports it when it
// occurs in more than half of the set.
// ----------------------------------------------------------------------------
//
//  Channel | Signals                                            | Direction
//  --------+----------------------------------------------------+-------------
//  item    | item_valid, item_stall, item.{value,last}          | into block
//  result  | result_valid, result_stall, result.{majority,found} | out of block
//
//  Loading takes one item per cycle while the block is in its load state.
//  After the item flagged last, each level of the search sweeps its items
//  through the single read port of a memory (one item per cycle), the
//  fallback unwind pops one entry per level, and the counting pass reads
//  the store once more.
//  The element store and level buffer need no clearing after reset.
//  item_stall is high from the last item until the result has been loaded
//  into the output register; a stalled result does not block loading of
//  the next set, only the end of its search.
//
module majority_element_pairing (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_stall,
    input  mep_pkg::in_item_t  item,
    output logic               result_valid,
    input  logic               result_stall,
    output mep_pkg::out_item_t result
);

    localparam int CW = mep_pkg::CNT_W;
    localparam int AW = mep_pkg::ADDR_W;
    localparam int DW = mep_pkg::DATA_W;

    // Sequencer state.
    mep_pkg::state_t state_reg;
    mep_pkg::state_t state_next;

    // Set size and the length of the level being reduced.
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic [CW-1:0] len_reg;
    logic [CW-1:0] len_next;

    // Read issue index, the index whose data arrives this cycle, and the
    // write pointer of the next level.
    logic [CW-1:0] rd_idx_reg;
    logic [CW-1:0] rd_idx_next;
    logic          pend_reg;
    logic          pend_next;
    logic [CW-1:0] pend_idx_reg;
    logic [CW-1:0] pend_idx_next;
    logic [CW-1:0] wr_ptr_reg;
    logic [CW-1:0] wr_ptr_next;

    // First element of the pair under test.
    logic [DW-1:0] held_reg;
    logic [DW-1:0] held_next;

    // The first level reads the element store; deeper levels read the
    // level buffer.
    logic          first_lvl_reg;
    logic          first_lvl_next;

    logic [DW-1:0] cand_reg;
    logic [DW-1:0] cand_next;
    logic [CW-1:0] occ_reg;
    logic [CW-1:0] occ_next;

    mep_pkg::out_item_t result_reg;
    mep_pkg::out_item_t result_next;
    logic               result_valid_reg;
    logic               result_valid_next;

    // Memory ports.
    logic          store_we;
    logic [DW-1:0] store_rdata;
    logic          lvl_we;
    logic [AW-1:0] lvl_waddr;
    logic [DW-1:0] lvl_wdata;
    logic [DW-1:0] lvl_rdata;
    logic [AW-1:0] rd_addr;
    logic [DW-1:0] rdata;

    // The shared equality comparator.
    logic [DW-1:0] cmp_a;
    logic [DW-1:0] cmp_b;
    logic          cmp_eq;

    mep_pkg::fb_ctrl_t fb_ctrl;
    mep_pkg::fb_top_t  fb_top;

    logic [CW-1:0] len_m1;
    logic [CW-1:0] count_m1;
    logic          out_free;
    logic          sweep_end;
    logic          count_end;

    assign len_m1    = len_reg - 1'b1;
    assign count_m1  = count_reg - 1'b1;
    assign out_free  = !result_valid_reg || !result_stall;
    assign sweep_end = pend_reg && (pend_idx_reg == len_m1);
    assign count_end = pend_reg && (pend_idx_reg == count_m1);

    assign item_stall   = (state_reg != mep_pkg::ST_LOAD);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // At level start the read of entry zero is issued, which serves a
    // level of a single item.
    assign rd_addr = (state_reg == mep_pkg::ST_LVL_START) ? '0 : rd_idx_reg[AW-1:0];
    assign rdata   = (first_lvl_reg || (state_reg == mep_pkg::ST_COUNT)) ?
                     store_rdata : lvl_rdata;

    mep_ram #(
        .DATA_W (DW),
        .ADDR_W (AW)
    ) u_store (
        .clk   (clk),
        .we    (store_we),
        .waddr (count_reg[AW-1:0]),
        .wdata (item.value),
        .raddr (rd_addr),
        .rdata (store_rdata)
    );

    mep_ram #(
        .DATA_W (DW),
        .ADDR_W (AW)
    ) u_level (
        .clk   (clk),
        .we    (lvl_we),
        .waddr (lvl_waddr),
        .wdata (lvl_wdata),
        .raddr (rd_addr),
        .rdata (lvl_rdata)
    );

    mep_fb_stack u_fb_stack (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (fb_ctrl),
        .top   (fb_top)
    );

    // The comparator tests pairs during a sweep, stored elements against
    // the candidate while counting, and the candidate against zero otherwise.
    always_comb
    begin
        unique case (state_reg)
            mep_pkg::ST_SWEEP:
            begin
                cmp_a = held_reg;
                cmp_b = rdata;
            end
            mep_pkg::ST_COUNT:
            begin
                cmp_a = rdata;
                cmp_b = cand_reg;
            end
            default:
            begin
                cmp_a = cand_reg;
                cmp_b = '0;
            end
        endcase
    end

    assign cmp_eq = (cmp_a == cmp_b);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mep_pkg::ST_LOAD:
            begin
                if (item_valid && item.last)
                begin
                    state_next = mep_pkg::ST_LVL_START;
                end
            end
            mep_pkg::ST_LVL_START:
            begin
                priority if (len_reg == '0)
                begin
                    state_next = mep_pkg::ST_UNWIND;
                end
                else if (len_reg == CW'(1))
                begin
                    state_next = mep_pkg::ST_CAND_RD;
                end
                else
                begin
                    state_next = mep_pkg::ST_SWEEP;
                end
            end
            mep_pkg::ST_SWEEP:
            begin
                if (sweep_end)
                begin
                    state_next = mep_pkg::ST_LVL_START;
                end
            end
            mep_pkg::ST_CAND_RD:
            begin
                state_next = mep_pkg::ST_UNWIND;
            end
            mep_pkg::ST_UNWIND:
            begin
                if (fb_top.empty)
                begin
                    state_next = mep_pkg::ST_COUNT;
                end
            end
            mep_pkg::ST_COUNT:
            begin
                if (count_end)
                begin
                    state_next = mep_pkg::ST_EMIT;
                end
            end
            mep_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = mep_pkg::ST_LOAD;
                end
            end
            default:
            begin
                state_next = mep_pkg::ST_LOAD;
            end
        endcase
    end

    // Datapath and memory control.
    always_comb
    begin
        count_next        = count_reg;
        len_next          = len_reg;
        rd_idx_next       = rd_idx_reg;
        pend_next         = 1'b0;
        pend_idx_next     = pend_idx_reg;
        wr_ptr_next       = wr_ptr_reg;
        held_next         = held_reg;
        first_lvl_next    = first_lvl_reg;
        cand_next         = cand_reg;
        occ_next          = occ_reg;
        result_next       = result_reg;
        result_valid_next = result_valid_reg && result_stall;
        store_we          = 1'b0;
        lvl_we            = 1'b0;
        lvl_waddr         = wr_ptr_reg[AW-1:0];
        lvl_wdata         = held_reg;
        fb_ctrl           = '0;

        unique case (state_reg)
            mep_pkg::ST_LOAD:
            begin
                if (item_valid)
                begin
                    // A full store drops the item, even one flagged last.
                    if (count_reg < mep_pkg::MAX_CNT)
                    begin
                        store_we   = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                    if (item.last)
                    begin
                        len_next       = count_next;
                        first_lvl_next = 1'b1;
                    end
                end
            end
            mep_pkg::ST_LVL_START:
            begin
                rd_idx_next = '0;
                wr_ptr_next = '0;
                if (len_reg == '0)
                begin
                    cand_next = '0;
                end
            end
            mep_pkg::ST_SWEEP:
            begin
                if (rd_idx_reg < len_reg)
                begin
                    rd_idx_next   = rd_idx_reg + 1'b1;
                    pend_next     = 1'b1;
                    pend_idx_next = rd_idx_reg;
                end
                if (pend_reg)
                begin
                    priority if (!pend_idx_reg[0])
                    begin
                        held_next = rdata;
                    end
                    else if (len_reg == CW'(2))
                    begin
                        // A level of two always reduces to its second item.
                        lvl_we    = 1'b1;
                        lvl_waddr = '0;
                        lvl_wdata = rdata;
                    end
                    else if (cmp_eq)
                    begin
                        lvl_we      = 1'b1;
                        wr_ptr_next = wr_ptr_reg + 1'b1;
                    end
                    if (sweep_end)
                    begin
                        fb_ctrl.push   = 1'b1;
                        fb_ctrl.odd    = len_reg[0];
                        fb_ctrl.value  = rdata;
                        first_lvl_next = 1'b0;
                        len_next       = (len_reg == CW'(2)) ? CW'(1) : wr_ptr_next;
                    end
                end
            end
            mep_pkg::ST_CAND_RD:
            begin
                cand_next = rdata;
            end
            mep_pkg::ST_UNWIND:
            begin
                if (!fb_top.empty)
                begin
                    // An odd level's last item stands in for a zero candidate.
                    fb_ctrl.pop = 1'b1;
                    if (fb_top.vld && cmp_eq)
                    begin
                        cand_next = fb_top.value;
                    end
                end
                else
                begin
                    rd_idx_next = '0;
                    occ_next    = '0;
                end
            end
            mep_pkg::ST_COUNT:
            begin
                if (rd_idx_reg < count_reg)
                begin
                    rd_idx_next   = rd_idx_reg + 1'b1;
                    pend_next     = 1'b1;
                    pend_idx_next = rd_idx_reg;
                end
                if (pend_reg && cmp_eq)
                begin
                    occ_next = occ_reg + 1'b1;
                end
            end
            mep_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    // Zero is the not-found mark, so a zero candidate never wins.
                    result_valid_next = 1'b1;
                    result_next.found = !cmp_eq && (occ_reg > (count_reg >> 1));
                    result_next.majority = result_next.found ? cand_reg : '0;
                    count_next = '0;
                end
            end
            default:
            begin
                count_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= mep_pkg::ST_LOAD;
            count_reg        <= '0;
            len_reg          <= '0;
            rd_idx_reg       <= '0;
            pend_reg         <= 1'b0;
            pend_idx_reg     <= '0;
            wr_ptr_reg       <= '0;
            first_lvl_reg    <= 1'b0;
            cand_reg         <= '0;
            occ_reg          <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            count_reg        <= count_next;
            len_reg          <= len_next;
            rd_idx_reg       <= rd_idx_next;
            pend_reg         <= pend_next;
            pend_idx_reg     <= pend_idx_next;
            wr_ptr_reg       <= wr_ptr_next;
            first_lvl_reg    <= first_lvl_next;
            cand_reg         <= cand_next;
            occ_reg          <= occ_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        held_reg   <= held_next;
        result_reg <= result_next;
    end

    // A level write never overtakes the reads of the same level.
    a_wr_behind_rd: assert property (@(posedge clk) disable iff (!rst_n)
        lvl_we |-> (wr_ptr_reg < pend_idx_reg))
        else $error("level write overtakes the read pointer");

    // The set size never exceeds the store.
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= mep_pkg::MAX_CNT)
        else $error("item count beyond store size");

    // Finishing a search empties the set and presents a result.
    a_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mep_pkg::ST_EMIT && out_free)
        |=> (count_reg == '0) && result_valid_reg && (state_reg == mep_pkg::ST_LOAD))
        else $error("result not presented after search");

    // A found result always carries a nonzero value, and a miss carries zero.
    a_found_value: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg |-> (result_reg.found == (result_reg.majority != '0)))
        else $error("found flag disagrees with majority value");

    // The fallback stack is pushed only at the end of a level sweep.
    a_push_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        fb_ctrl.push |-> (state_reg == mep_pkg::ST_SWEEP) && sweep_end)
        else $error("fallback push outside a level end");

endmodule
